@@ hdl/page_bitmap_allocator_macros.svh @@
// Assertion helpers shared by the allocator RTL.
// PBA_ASSERT is disabled while reset is asserted.
// PBA_ASSERT_ALWAYS is checked at every rising clock edge, in reset too.
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PBA_ASSERT(lbl, prop, msg)
`define PBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/pba_pkg.sv @@
package pba_pkg;

    localparam int ADDR_W   = 52;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;

    localparam logic [ADDR_W-1:0] BASE_RESET = 52'h0_0000_0010_0000;

    // Configuration port geometry: one 64-bit register at byte offset 0.
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam int REG_IDX_LSB = 3;
    localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_BASE_ADDRESS = 1'b0;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FCHK,
        S_MOD,
        S_ADDR,
        S_DONE
    } t_state;

endpackage

@@ hdl/pba_if.sv @@
interface pba_req_if import pba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, mode, free_address, input ready);
    modport sink   (input valid, mode, free_address, output ready);
endinterface

interface pba_rsp_if import pba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   frame_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, frame_address, status, input ready);
    modport sink   (input valid, frame_address, status, output ready);
endinterface

@@ hdl/pba_bitmap_ram.sv @@
module pba_bitmap_ram import pba_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pba_cfg_regs.sv @@
module pba_cfg_regs import pba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ADDR_W-1:0]  o_base_address
);

    logic [ADDR_W-1:0] r_base;
    logic              sel_base;

    assign sel_base = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_BASE_ADDRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (psel && penable && pwrite && sel_base) begin
            r_base <= pwdata[ADDR_W-1:0];
        end
    end

    assign prdata         = sel_base ? PDATA_W'(r_base) : '0;
    assign pready         = 1'b1;
    assign o_base_address = r_base;

endmodule

@@ hdl/page_bitmap_allocator.sv @@
// First-fit page frame allocator over a used-bit map of FRAME_COUNT frames.
// Requests arrive on i_req (valid/ready): mode 0 allocates the lowest free
// frame, mode 1 frees the frame holding free_address. Each request yields
// exactly one response transaction on o_rsp with frame_address and status
// (0 ok, 1 no free frame, 2 free address out of range).
// The bitmap sits in a single RAM of 32-bit words that is read, modified and
// written back. An allocation passes S_PREP, S_MOD (again for every full bitmap
// word the scan steps over), S_ADDR and S_DONE; an in-range free passes S_PREP,
// S_FCHK, S_MOD and S_DONE, a free out of range skips S_MOD, and an allocation
// with no word left goes from S_PREP to S_DONE. The response is registered on
// leaving S_DONE, and only then is the next request accepted. A hint pointer
// keeps the scan starting at the lowest word that may hold a free frame, and a
// high-water mark makes never-written words read as free, so reset needs no
// clearing pass and takes effect at once. The user must write base_address
// over the APB port only while the block is idle; the block does not enforce
// it. The response register holds a result while o_rsp is stalled; the next
// request is still accepted and worked on, and waits only to be delivered.
module page_bitmap_allocator import pba_pkg::*; #(
    parameter int FRAME_COUNT = 4096,
    parameter int FRAME_SHIFT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pba_req_if.sink            i_req,
    pba_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "page_bitmap_allocator_macros.svh"

    localparam int NW        = (FRAME_COUNT + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (NW > 1) ? $clog2(NW) : 1;
    localparam int HW        = $clog2(NW + 1);
    localparam int LAST_BITS = FRAME_COUNT - (NW - 1) * WORD_W;
    localparam int IH_W      = ADDR_W - FRAME_SHIFT;
    localparam logic [WORD_W-1:0] TAIL_MASK =
        (LAST_BITS == WORD_W) ? '0 : ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
    localparam logic [IH_W-1:0] FC_LIM   = IH_W'(FRAME_COUNT);
    localparam logic [HW-1:0]   NW_H     = HW'(NW);
    localparam logic [WA_W-1:0] LAST_W   = WA_W'(NW - 1);

    logic [ADDR_W-1:0] base_address;

    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [ADDR_W-1:0] r_free, n_free;
    logic [ADDR_W:0]   r_diff, n_diff;
    logic [WA_W-1:0]   r_word, n_word;
    logic [HW-1:0]     r_hint, n_hint;
    logic [HW-1:0]     r_hwm, n_hwm;
    logic [BIT_W-1:0]  r_bit, n_bit;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_res, n_res;

    logic                r_ovalid;
    logic [ADDR_W-1:0]   r_oaddr;
    t_status             r_ostatus;
    logic                out_load;

    logic              mem_re, mem_we;
    logic [WA_W-1:0]   mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    logic [WORD_W-1:0] word_data;
    logic [WORD_W-1:0] avail;
    logic [BIT_W-1:0]  first_bit;
    logic [BIT_W-1:0]  free_bit;
    logic [WA_W-1:0]   free_word;
    logic              range_bad;
    logic [HW-1:0]     word_ext;
    logic [HW-1:0]     word_inc;
    logic [HW-1:0]     hint_inc;

    pba_cfg_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_base_address (base_address)
    );

    pba_bitmap_ram #(
        .DEPTH (NW),
        .AW    (WA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_word),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Words at or above the high-water mark have never been allocated from.
    assign word_ext  = HW'(r_word);
    assign word_inc  = word_ext + HW'(1);
    assign hint_inc  = r_hint + HW'(1);
    assign word_data = (word_ext >= r_hwm) ? '0 : mem_rdata;
    assign avail     = ~(word_data | ((r_word == LAST_W) ? TAIL_MASK : '0));

    always_comb begin
        first_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (avail[b]) begin
                first_bit = BIT_W'(b);
            end
        end
    end

    assign range_bad = r_diff[ADDR_W] || (r_diff[ADDR_W-1:FRAME_SHIFT] >= FC_LIM);
    assign free_bit  = r_diff[FRAME_SHIFT +: BIT_W];
    assign free_word = r_diff[FRAME_SHIFT + BIT_W +: WA_W];

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_free    = r_free;
        n_diff    = r_diff;
        n_word    = r_word;
        n_hint    = r_hint;
        n_hwm     = r_hwm;
        n_bit     = r_bit;
        n_status  = r_status;
        n_res     = r_res;
        mem_re    = 1'b0;
        mem_raddr = r_word;
        mem_we    = 1'b0;
        mem_wdata = word_data;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_free  = i_req.free_address;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_mode == MODE_FREE) begin
                    n_diff  = {1'b0, r_free} - {1'b0, base_address};
                    n_state = S_FCHK;
                end else if (r_hint == NW_H) begin
                    n_status = ST_FULL;
                    n_res    = '0;
                    n_state  = S_DONE;
                end else begin
                    n_word    = r_hint[WA_W-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = r_hint[WA_W-1:0];
                    n_state   = S_MOD;
                end
            end
            S_FCHK: begin
                if (range_bad) begin
                    n_status = ST_RANGE;
                    n_res    = '0;
                    n_state  = S_DONE;
                end else begin
                    n_word    = free_word;
                    mem_re    = 1'b1;
                    mem_raddr = free_word;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (r_mode == MODE_FREE) begin
                    mem_we    = 1'b1;
                    mem_wdata = word_data & ~(WORD_W'(1) << free_bit);
                    if (word_ext < r_hint) begin
                        n_hint = word_ext;
                    end
                    n_status = ST_OK;
                    n_res    = '0;
                    n_state  = S_DONE;
                end else if (avail == '0) begin
                    // Word is full: move the hint on and read the next word, or report full after the last.
                    n_hint = hint_inc;
                    if (hint_inc == NW_H) begin
                        n_status = ST_FULL;
                        n_res    = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_word    = hint_inc[WA_W-1:0];
                        mem_re    = 1'b1;
                        mem_raddr = hint_inc[WA_W-1:0];
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = word_data | (WORD_W'(1) << first_bit);
                    n_bit     = first_bit;
                    if (word_inc > r_hwm) begin
                        n_hwm = word_inc;
                    end
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_res    = base_address + (ADDR_W'({r_word, r_bit}) << FRAME_SHIFT);
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hint  <= '0;
            r_hwm   <= '0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_hwm   <= n_hwm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_free   <= n_free;
        r_diff   <= n_diff;
        r_word   <= n_word;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oaddr   <= r_res;
            r_ostatus <= r_status;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.frame_address = r_oaddr;
    assign o_rsp.status        = r_ostatus;

    `PBA_ASSERT(a_hint_below_hwm, r_hint <= r_hwm, "scan hint passed the high-water mark")
    `PBA_ASSERT(a_full_after_scan, (r_state == S_DONE && r_status == ST_FULL) |-> (r_hint == NW_H), "full reported before the scan reached the end")
    `PBA_ASSERT(a_accept_starts, (i_req.valid && i_req.ready) |=> (r_state == S_PREP), "accepted request did not start")
    `PBA_ASSERT(a_error_zero_addr, (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.frame_address == '0), "error response with nonzero address")
    `PBA_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_ovalid), "reset did not idle the block")

endmodule

@@ dv/pba_checker.sv @@
module pba_checker import pba_pkg::*; #(
    parameter int FRAME_COUNT = 4096,
    parameter int FRAME_SHIFT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pba_req_if                 i_req,
    pba_rsp_if                 i_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        t_status           status;
    } t_alloc_result;

    bit                frame_used [FRAME_COUNT];
    logic [ADDR_W-1:0] base_address;
    t_alloc_result     expected_q [$];
    t_alloc_result     oldest;
    int                fail_total;

    // Applies one request to the shadow bitmap and returns the response it must produce.
    function automatic t_alloc_result apply_request(input logic mode,
                                                    input logic [ADDR_W-1:0] addr);
        t_alloc_result     res;
        int                lowest_free;
        logic [ADDR_W-1:0] frame_index;
        res.frame_address = '0;
        res.status = ST_OK;
        if (mode == MODE_ALLOC) begin
            lowest_free = -1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (!frame_used[i]) begin
                    lowest_free = i;
                    break;
                end
            end
            if (lowest_free < 0) begin
                res.status = ST_FULL;
            end else begin
                frame_used[lowest_free] = 1'b1;
                // The sum wraps at the address width on purpose.
                res.frame_address = base_address + (ADDR_W'(lowest_free) << FRAME_SHIFT);
            end
        end else if (addr < base_address) begin
            res.status = ST_RANGE;
        end else begin
            frame_index = (addr - base_address) >> FRAME_SHIFT;
            if (frame_index >= ADDR_W'(FRAME_COUNT)) begin
                res.status = ST_RANGE;
            end else begin
                frame_used[int'(frame_index)] = 1'b0;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_used[i]) frame_used[i] = 1'b0;
            base_address = BASE_RESET;
            expected_q.delete();
            fail_total = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected response transaction: frame_address %h, status %0d",
                           i_rsp.frame_address, i_rsp.status);
                    fail_total++;
                end else begin
                    oldest = expected_q.pop_front();
                    if (i_rsp.frame_address !== oldest.frame_address) begin
                        $error("frame_address mismatch: expected %h, got %h",
                               oldest.frame_address, i_rsp.frame_address);
                        fail_total++;
                    end
                    if (i_rsp.status !== oldest.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               oldest.status, i_rsp.status);
                        fail_total++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_q.push_back(apply_request(i_req.mode, i_req.free_address));
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[PADDR_W-1:REG_IDX_LSB] == REG_BASE_ADDRESS) begin
                base_address = i_pwdata[ADDR_W-1:0];
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_q.size();
    end

endmodule

@@ dv/testbench.sv @@
module testbench;
    import pba_pkg::*;

    localparam int FRAME_COUNT = 4096;
    localparam int FRAME_SHIFT = 12;

    localparam logic [ADDR_W-1:0]  ADDR_MAX    = '1;
    localparam logic [ADDR_W-1:0]  FRAME_BYTES = ADDR_W'(1) << FRAME_SHIFT;
    localparam logic [ADDR_W-1:0]  POOL_BYTES  = ADDR_W'(FRAME_COUNT) << FRAME_SHIFT;
    localparam logic [PADDR_W-1:0] PADDR_BASE  = PADDR_W'(REG_BASE_ADDRESS) << REG_IDX_LSB;
    localparam logic [PADDR_W-1:0] PADDR_UNMAPPED = PADDR_BASE ^ (PADDR_W'(1) << REG_IDX_LSB);

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                fail_count;
    int                pending;
    bit                sender_idle;
    bit                stall_enable;
    logic [ADDR_W-1:0] cur_base;
    int                alloc_total;

    pba_req_if req_ch ();
    pba_rsp_if rsp_ch ();

    page_bitmap_allocator #(
        .FRAME_COUNT (FRAME_COUNT),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pba_checker #(
        .FRAME_COUNT (FRAME_COUNT),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [ADDR_W-1:0] frame_addr(input int idx,
                                                     input logic [ADDR_W-1:0] offset);
        return cur_base + (ADDR_W'(idx) << FRAME_SHIFT) + offset;
    endfunction

    // An idle burst may come before the transaction, and valid stays high after acceptance.
    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.free_address <= addr;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic send_alloc();
        send_request(MODE_ALLOC, rand_addr());
        alloc_total++;
    endtask

    task automatic send_free(input logic [ADDR_W-1:0] addr);
        send_request(MODE_FREE, addr);
    endtask

    // The pending count is registered, hence the edge before looking at it.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_base(input logic [ADDR_W-1:0] b);
        drain();
        apb_write(PADDR_BASE, (PDATA_W'($urandom) << ADDR_W) | PDATA_W'(b));
        if ($urandom_range(0, 1) == 0) begin
            apb_write(PADDR_UNMAPPED, PDATA_W'({$urandom, $urandom}));
        end
        cur_base = b;
    endtask

    // Mostly allocations and frees of frames near the used region, with some
    // boundary addresses and fully random addresses mixed in.
    task automatic issue_random(input int count, input int alloc_pct);
        int r;
        int span;
        int idx;
        logic [ADDR_W-1:0] small_ofs;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            span = (alloc_total + 8 < FRAME_COUNT) ? alloc_total + 8 : FRAME_COUNT - 1;
            small_ofs = ADDR_W'($urandom_range(0, 3 << FRAME_SHIFT));
            if (r < alloc_pct) begin
                send_alloc();
            end else if (r < 84) begin
                idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_COUNT - 1)
                                                  : $urandom_range(0, span);
                send_free(frame_addr(idx, ADDR_W'($urandom) & (FRAME_BYTES - 1)));
            end else if (r < 92) begin
                case ($urandom_range(0, 3))
                    0: send_free(cur_base - 1 - small_ofs);
                    1: send_free(cur_base + POOL_BYTES + small_ofs);
                    2: send_free(cur_base + POOL_BYTES - 1 - small_ofs);
                    default: send_free(cur_base);
                endcase
            end else begin
                send_free(rand_addr());
            end
        end
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (stall_enable && $urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial begin
        #30000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] b;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode <= MODE_ALLOC;
        req_ch.free_address <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cur_base = BASE_RESET;
        alloc_total = 0;
        sender_idle = 1'b1;
        stall_enable = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset base.
        send_free(cur_base);
        repeat (3) send_alloc();
        send_free(frame_addr(1, FRAME_BYTES - 1));
        send_alloc();
        send_free(cur_base - 1);
        send_free('0);
        send_free(cur_base + POOL_BYTES);
        send_free(cur_base + POOL_BYTES - 1);
        send_free(ADDR_MAX);
        drain();
        apb_write(PADDR_UNMAPPED, PDATA_W'({$urandom, $urandom}));
        send_alloc();
        set_base('0);
        send_free('0);
        send_alloc();
        // At the top of the address space every frame but the first wraps around.
        set_base(ADDR_MAX);
        send_alloc();
        send_free(ADDR_MAX);
        send_free('0);
        send_alloc();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: b = '0;
                1: b = ADDR_MAX;
                2: b = ADDR_MAX - (ADDR_W'($urandom_range(0, 2 * FRAME_COUNT)) << FRAME_SHIFT);
                3: b = rand_addr();
                4: b = rand_addr() & ~(FRAME_BYTES - 1);
                default: b = BASE_RESET;
            endcase
            sender_idle = $urandom_range(0, 3) != 0;
            stall_enable = $urandom_range(0, 3) != 0;
            set_base(b);
            issue_random(60, 45);
        end

        // Last part without idling: release frames all over the map, then refill.
        sender_idle = 1'b0;
        stall_enable = 1'b0;
        issue_random(150, 10);
        issue_random(220, 55);

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
